>>> rtl/mtkd_pkg.sv
package mtkd_pkg;

   localparam int TIME_BITS_DEF = 32;

   localparam int NUM_KEYS   = 20;
   localparam int KEY_W      = 5;
   localparam int TAP_W      = 4;
   localparam int CHAR_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int FIFO_DEPTH = 4;

   localparam logic [CHAR_W-1:0] BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] K_LEFT    = 8'hB4;
   localparam logic [CHAR_W-1:0] K_UP      = 8'hB5;
   localparam logic [CHAR_W-1:0] K_DOWN    = 8'hB6;
   localparam logic [CHAR_W-1:0] K_RIGHT   = 8'hB7;
   localparam logic [CHAR_W-1:0] K_ENTER   = 8'h0D;
   localparam logic [CHAR_W-1:0] K_CANCEL  = 8'h1B;
   localparam logic [CHAR_W-1:0] K_HOME    = 8'hD2;
   localparam logic [CHAR_W-1:0] K_CTXMENU = 8'hED;
   localparam logic [CHAR_W-1:0] K_KBENTER = 8'hB0;

   localparam logic [15:0] TAP_WINDOW_RST = 16'd300;
   localparam logic [15:0] LONG_PRESS_RST = 16'd600;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE   = 2'd0,
      REG_WINDOW = 2'd1,
      REG_LONG   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] event_byte;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic        continuous_mode;
      logic [15:0] tap_window_ms;
      logic [15:0] long_press_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]      count;
      rsp_type [1:0]   beat;
   } push_type;

   typedef struct packed {
      logic             vld;
      logic [KEY_W-1:0] key;
   } key_type;

   function automatic key_type key_decode(input logic [6:0] code);
      key_type    r;
      logic [6:0] c;
      logic [2:0] row;
      logic [6:0] col;
      logic [6:0] k;
      c   = code - 7'd1;
      row = 3'd0;
      col = c;
      if (c < 7'd10) begin
         row = 3'd0;
         col = c;
      end else if (c < 7'd20) begin
         row = 3'd1;
         col = c - 7'd10;
      end else if (c < 7'd30) begin
         row = 3'd2;
         col = c - 7'd20;
      end else if (c < 7'd40) begin
         row = 3'd3;
         col = c - 7'd30;
      end else begin
         row = 3'd4;
         col = c - 7'd40;
      end
      k     = {2'b00, row, 2'b00} + col;
      r.vld = (code != 7'd0) && (c < 7'd50) && (k < 7'(NUM_KEYS));
      r.key = k[KEY_W-1:0];
      return r;
   endfunction

   function automatic logic [TAP_W-1:0] tap_len(input logic [KEY_W-1:0] k);
      logic [TAP_W-1:0] n;
      case (k)
         5'd1, 5'd3:                  n = 4'd5;
         5'd5, 5'd7:                  n = 4'd9;
         5'd6, 5'd9, 5'd10, 5'd11,
         5'd14, 5'd15:                n = 4'd7;
         default:                     n = 4'd1;
      endcase
      return n;
   endfunction

   function automatic logic [CHAR_W-1:0] letter_char(input logic [CHAR_W-1:0] base,
                                                      input logic [TAP_W-1:0] n,
                                                      input logic [CHAR_W-1:0] digit,
                                                      input logic [TAP_W-1:0] t);
      logic [CHAR_W-1:0] ch;
      if (t < n) begin
         ch = base + {4'd0, t};
      end else if (t < {n[TAP_W-2:0], 1'b0}) begin
         ch = base - 8'd32 + {4'd0, t} - {4'd0, n};
      end else begin
         ch = digit;
      end
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] key_char(input logic [KEY_W-1:0] k,
                                                   input logic [TAP_W-1:0] t);
      logic [CHAR_W-1:0] ch;
      ch = 8'h00;
      case (k)
         5'd0:  ch = " ";
         5'd1: begin
            case (t)
               4'd0:    ch = ".";
               4'd1:    ch = ",";
               4'd2:    ch = "?";
               4'd3:    ch = "!";
               4'd4:    ch = "*";
               default: ch = 8'h00;
            endcase
         end
         5'd2:  ch = "0";
         5'd3: begin
            case (t)
               4'd0:    ch = ":";
               4'd1:    ch = ";";
               4'd2:    ch = "-";
               4'd3:    ch = "+";
               4'd4:    ch = "#";
               default: ch = 8'h00;
            endcase
         end
         5'd4:  ch = BACKSPACE;
         5'd5:  ch = letter_char("p", 4'd4, "7", t);
         5'd6:  ch = letter_char("t", 4'd3, "8", t);
         5'd7:  ch = letter_char("w", 4'd4, "9", t);
         5'd8:  ch = K_DOWN;
         5'd9:  ch = letter_char("g", 4'd3, "4", t);
         5'd10: ch = letter_char("j", 4'd3, "5", t);
         5'd11: ch = letter_char("m", 4'd3, "6", t);
         5'd12: ch = K_ENTER;
         5'd13: ch = "1";
         5'd14: ch = letter_char("a", 4'd3, "2", t);
         5'd15: ch = letter_char("d", 4'd3, "3", t);
         5'd16: ch = K_UP;
         5'd17: ch = K_CANCEL;
         5'd18: ch = K_HOME;
         5'd19: ch = K_CTXMENU;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [CHAR_W-1:0] long_code(input logic [KEY_W-1:0] k);
      logic [CHAR_W-1:0] ch;
      case (k)
         5'd8:    ch = K_LEFT;
         5'd12:   ch = K_KBENTER;
         5'd16:   ch = K_RIGHT;
         5'd17:   ch = K_CANCEL;
         5'd18:   ch = K_HOME;
         5'd19:   ch = K_CTXMENU;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/mtkd_engine.sv
module mtkd_engine #(
   parameter int TIME_BITS = mtkd_pkg::TIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  mtkd_pkg::req_type  item,
   input  mtkd_pkg::cfg_type  cfg,
   output mtkd_pkg::push_type push
);

   logic                          held_vld_ff, held_vld_in;
   logic [mtkd_pkg::KEY_W-1:0]    held_key_ff, held_key_in;
   logic [TIME_BITS-1:0]          held_since_ff, held_since_in;
   logic                          pend_vld_ff, pend_vld_in;
   logic [mtkd_pkg::KEY_W-1:0]    pend_key_ff, pend_key_in;
   logic [mtkd_pkg::TAP_W-1:0]    pend_tap_ff, pend_tap_in;
   logic [TIME_BITS-1:0]          pend_since_ff, pend_since_in;

   logic [TIME_BITS-1:0]          now;
   logic [TIME_BITS-1:0]          pend_age;
   logic [TIME_BITS-1:0]          held_age;
   mtkd_pkg::key_type             dec;
   logic                          ev_ok;
   logic                          pressed;
   logic                          expired;
   logic                          pv1;
   logic                          rel;
   logic                          long_br;
   logic                          plain_br;
   logic                          cyc_br;
   logic                          cnt;
   logic [mtkd_pkg::TAP_W-1:0]    len;
   logic [mtkd_pkg::TAP_W-1:0]    tap_inc;
   logic [mtkd_pkg::TAP_W-1:0]    new_tap;
   logic                          cm_en, bs_en, fin_en;
   logic [mtkd_pkg::CHAR_W-1:0]   cm_char, fin_char;
   mtkd_pkg::rsp_type             b0, b1;
   logic [1:0]                    n;

   assign now      = TIME_BITS'(item.now_ms);
   assign pend_age = now - pend_since_ff;
   assign held_age = now - held_since_ff;
   assign dec      = mtkd_pkg::key_decode(item.event_byte[6:0]);
   assign pressed  = item.event_byte[7];
   assign ev_ok    = item.kind && dec.vld;

   assign expired  = pend_vld_ff && (pend_age >= TIME_BITS'(cfg.tap_window_ms));
   assign pv1      = pend_vld_ff && !expired;

   assign rel      = ev_ok && !pressed && held_vld_ff && (held_key_ff == dec.key);
   assign len      = mtkd_pkg::tap_len(dec.key);
   assign long_br  = (mtkd_pkg::long_code(dec.key) != 8'h00) &&
                     (held_age >= TIME_BITS'(cfg.long_press_ms));
   assign plain_br = !long_br && (len <= 4'd1);
   assign cyc_br   = !long_br && !plain_br;
   assign cnt      = pv1 && (pend_key_ff == dec.key);

   assign tap_inc  = pend_tap_ff + 4'd1;
   assign new_tap  = !cnt ? 4'd0 : ((tap_inc == len) ? 4'd0 : tap_inc);

   assign cm_char  = mtkd_pkg::key_char(pend_key_ff, pend_tap_ff);
   assign cm_en    = !cfg.continuous_mode && pend_vld_ff &&
                     (expired || (rel && !(cyc_br && cnt)));
   assign bs_en    = cfg.continuous_mode && rel && !plain_br && cnt;
   assign fin_en   = rel && (long_br || plain_br || cfg.continuous_mode);

   always_comb begin
      if (long_br) begin
         fin_char = mtkd_pkg::long_code(dec.key);
      end else if (plain_br) begin
         fin_char = mtkd_pkg::key_char(dec.key, 4'd0);
      end else begin
         fin_char = mtkd_pkg::key_char(dec.key, new_tap);
      end
   end

   always_comb begin
      b0 = '0;
      b1 = '0;
      n  = 2'd0;
      if (cm_en) begin
         b0.char_out = cm_char;
         if (fin_en) begin
            b1.char_out = fin_char;
            n = 2'd2;
         end else begin
            n = 2'd1;
         end
      end else if (bs_en) begin
         b0.char_out = mtkd_pkg::BACKSPACE;
         b1.char_out = fin_char;
         n = 2'd2;
      end else if (fin_en) begin
         b0.char_out = fin_char;
         n = 2'd1;
      end
      b0.last = (n == 2'd1);
      b1.last = (n == 2'd2);
   end

   always_comb begin
      push.count   = go ? n : 2'd0;
      push.beat[0] = b0;
      push.beat[1] = b1;
   end

   always_comb begin
      held_vld_in   = held_vld_ff;
      held_key_in   = held_key_ff;
      held_since_in = held_since_ff;
      pend_vld_in   = pv1;
      pend_key_in   = pend_key_ff;
      pend_tap_in   = pend_tap_ff;
      pend_since_in = pend_since_ff;
      if (ev_ok && pressed) begin
         held_vld_in   = 1'b1;
         held_key_in   = dec.key;
         held_since_in = now;
      end
      if (rel) begin
         held_vld_in = 1'b0;
         pend_vld_in = cyc_br;
         if (cyc_br) begin
            pend_key_in   = dec.key;
            pend_tap_in   = new_tap;
            pend_since_in = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else if (go) begin
         held_vld_ff <= held_vld_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         held_key_ff   <= held_key_in;
         held_since_ff <= held_since_in;
         pend_key_ff   <= pend_key_in;
         pend_tap_ff   <= pend_tap_in;
         pend_since_ff <= pend_since_in;
      end
   end

endmodule

>>> rtl/mtkd_fifo.sv
module mtkd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  mtkd_pkg::push_type push,
   input  logic               pop,
   output mtkd_pkg::rsp_type  head,
   output logic               head_vld,
   output logic               room2
);

   localparam int DEPTH = mtkd_pkg::FIFO_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mtkd_pkg::rsp_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   assign head     = mem_ff[rd_ptr_ff];
   assign head_vld = (cnt_ff != '0);
   assign room2    = (cnt_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.beat[0];
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.beat[1];
      end
   end

endmodule

>>> rtl/multitap_keypad_decoder.sv
// Multi-tap keypad decoder. Each request beat is a poll or a raw key event with a
// millisecond time stamp; each response beat is one character, with last set on the
// final character of its request. An accepted request is registered and decoded,
// once the queue has room for two characters, against the held-key and pending-cycle
// state, giving zero, one or two characters into a four-entry response queue. A new
// request is taken every cycle while the queue has room for two characters, so requests
// that give at most one character stream at one per cycle; the sustained rate is set by
// the response port, which delivers one character per cycle while rsp_stall is low.
// Configuration writes take effect at once and are meant for an idle block.
module multitap_keypad_decoder #(
   parameter int TIME_BITS = mtkd_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mtkd_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mtkd_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_wen,
   input  logic [mtkd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mtkd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mtkd_pkg::cfg_type   cfg_ff;
   logic                s1_vld_ff, s1_vld_in;
   mtkd_pkg::req_type   s1_item_ff;
   logic                go;
   logic                room2;
   logic                accept;
   mtkd_pkg::push_type  push;

   assign go        = s1_vld_ff && room2;
   assign req_stall = s1_vld_ff && !go;
   assign accept    = req_valid && !req_stall;
   assign s1_vld_in = accept ? 1'b1 : (go ? 1'b0 : s1_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.continuous_mode <= 1'b0;
         cfg_ff.tap_window_ms   <= mtkd_pkg::TAP_WINDOW_RST;
         cfg_ff.long_press_ms   <= mtkd_pkg::LONG_PRESS_RST;
      end else if (csr_wen) begin
         case (csr_index)
            mtkd_pkg::REG_MODE:   cfg_ff.continuous_mode <= csr_wdata[0];
            mtkd_pkg::REG_WINDOW: cfg_ff.tap_window_ms   <= csr_wdata;
            mtkd_pkg::REG_LONG:   cfg_ff.long_press_ms   <= csr_wdata;
            default: ;
         endcase
      end
   end

   mtkd_engine #(
      .TIME_BITS (TIME_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .push  (push)
   );

   mtkd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop      (rsp_valid && !rsp_stall),
      .head     (rsp_payload),
      .head_vld (rsp_valid),
      .room2    (room2)
   );

endmodule

>>> test/tb_multitap_keypad_decoder.sv
module tb_multitap_keypad_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NO_KEY      = 255;
   localparam int CYCLE_LIMIT = 400000;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   mtkd_pkg::req_type               req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   mtkd_pkg::rsp_type               rsp_payload;
   logic                            csr_wen     = 1'b0;
   logic [mtkd_pkg::CSR_IDX_W-1:0]  csr_index   = '0;
   logic [mtkd_pkg::CSR_DATA_W-1:0] csr_wdata   = '0;

   logic        cfg_cont = 1'b0;
   logic [15:0] cfg_win  = mtkd_pkg::TAP_WINDOW_RST;
   logic [15:0] cfg_long = mtkd_pkg::LONG_PRESS_RST;
   int          held_key = NO_KEY;
   logic [31:0] held_at  = '0;
   int          cyc_key  = NO_KEY;
   int          cyc_tap  = 0;
   logic [31:0] cyc_at   = '0;

   logic [7:0]        char_buf[$];
   mtkd_pkg::rsp_type char_due_q[$];
   mtkd_pkg::req_type key_beat_q[$];
   logic [31:0]       ms_now = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_len      = 0;
   int hold_seq      = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int fail_cnt      = 0;
   int cycle_cnt     = 0;
   int beat_cnt      = 0;

   multitap_keypad_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int tap_count(input int k);
      case (k)
         1, 3:                  return 5;
         5, 7:                  return 9;
         6, 9, 10, 11, 14, 15:  return 7;
         default:               return 1;
      endcase
   endfunction

   function automatic logic [7:0] key_glyph(input int k, input int t);
      string s;
      case (k)
         0:       return " ";
         1:       s = ".,?!*";
         2:       return "0";
         3:       s = ":;-+#";
         4:       return mtkd_pkg::BACKSPACE;
         5:       s = "pqrsPQRS7";
         6:       s = "tuvTUV8";
         7:       s = "wxyzWXYZ9";
         8:       return mtkd_pkg::K_DOWN;
         9:       s = "ghiGHI4";
         10:      s = "jklJKL5";
         11:      s = "mnoMNO6";
         12:      return mtkd_pkg::K_ENTER;
         13:      return "1";
         14:      s = "abcABC2";
         15:      s = "defDEF3";
         16:      return mtkd_pkg::K_UP;
         17:      return mtkd_pkg::K_CANCEL;
         18:      return mtkd_pkg::K_HOME;
         default: return mtkd_pkg::K_CTXMENU;
      endcase
      return s[t];
   endfunction

   function automatic logic [7:0] hold_code(input int k);
      case (k)
         8:       return mtkd_pkg::K_LEFT;
         12:      return mtkd_pkg::K_KBENTER;
         16:      return mtkd_pkg::K_RIGHT;
         17:      return mtkd_pkg::K_CANCEL;
         18:      return mtkd_pkg::K_HOME;
         19:      return mtkd_pkg::K_CTXMENU;
         default: return 8'h00;
      endcase
   endfunction

   task automatic put_char(input logic [7:0] c);
      if (char_buf.size() < 3) char_buf.push_back(c);
   endtask

   task automatic close_cycle;
      if (cyc_key < mtkd_pkg::NUM_KEYS && !cfg_cont)
         put_char(key_glyph(cyc_key, cyc_tap % tap_count(cyc_key)));
      cyc_key = NO_KEY;
   endtask

   task automatic predict_chars(input mtkd_pkg::req_type b);
      logic [31:0]       now;
      logic [31:0]       age;
      logic [31:0]       dur;
      int                c;
      int                k;
      logic              cont;
      mtkd_pkg::rsp_type r;
      char_buf.delete();
      now = b.now_ms;
      age = now - cyc_at;
      if (cyc_key != NO_KEY && age >= cfg_win) close_cycle();
      c = b.event_byte[6:0];
      k = ((c - 1) / 10) * 4 + (c - 1) % 10;
      if (b.kind && c != 0 && k < mtkd_pkg::NUM_KEYS) begin
         if (b.event_byte[7]) begin
            held_key = k;
            held_at  = now;
         end else if (held_key == k) begin
            dur      = now - held_at;
            held_key = NO_KEY;
            if (hold_code(k) != 0 && dur >= cfg_long) begin
               if (cfg_cont && cyc_key == k) put_char(mtkd_pkg::BACKSPACE);
               else close_cycle();
               cyc_key = NO_KEY;
               put_char(hold_code(k));
            end else if (tap_count(k) <= 1) begin
               close_cycle();
               put_char(key_glyph(k, 0));
            end else begin
               cont = (cyc_key == k) && (age < cfg_win);
               if (!cont) begin
                  close_cycle();
                  cyc_key = k;
                  cyc_tap = 0;
               end else begin
                  cyc_tap = (cyc_tap + 1) % tap_count(k);
               end
               cyc_at = now;
               if (cfg_cont) begin
                  if (cont) put_char(mtkd_pkg::BACKSPACE);
                  put_char(key_glyph(k, cyc_tap));
               end
            end
         end
      end
      foreach (char_buf[i]) begin
         r.char_out = char_buf[i];
         r.last     = (i == char_buf.size() - 1);
         char_due_q.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_chars(req_payload);
         if (!req_valid || !req_stall) begin
            if (key_beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= key_beat_q.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      mtkd_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (char_due_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
               $display("unexpected response beat: char %02h last %0d",
                        rsp_payload.char_out, rsp_payload.last);
         end else begin
            e = char_due_q.pop_front();
            if (rsp_payload !== e) begin
               fail_cnt++;
               if (fail_cnt <= 10)
                  $display("beat mismatch: expected char %02h last %0d, got char %02h last %0d",
                           e.char_out, e.last, rsp_payload.char_out, rsp_payload.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [6:0] code_of(input int k, input logic alt);
      if (alt && k >= 4) return 7'((k / 4 - 1) * 10 + k % 4 + 5);
      return 7'((k / 4) * 10 + k % 4 + 1);
   endfunction

   task automatic send(input logic kind, input logic [7:0] ev);
      mtkd_pkg::req_type b;
      b.kind       = kind;
      b.event_byte = ev;
      b.now_ms     = ms_now;
      key_beat_q.push_back(b);
      beat_cnt++;
   endtask

   task automatic press(input int k, input logic alt);
      send(1'b1, {1'b1, code_of(k, alt)});
   endtask

   task automatic lift(input int k, input logic alt);
      send(1'b1, {1'b0, code_of(k, alt)});
   endtask

   task automatic key_tap(input int k, input logic [31:0] hold_ms, input logic [31:0] gap_ms);
      press(k, 1'($urandom_range(1)));
      ms_now += hold_ms;
      lift(k, 1'($urandom_range(1)));
      ms_now += gap_ms;
   endtask

   task automatic set_reg(input mtkd_pkg::csr_index_type idx, input logic [15:0] val);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         mtkd_pkg::REG_MODE:   cfg_cont = val[0];
         mtkd_pkg::REG_WINDOW: cfg_win  = val;
         mtkd_pkg::REG_LONG:   cfg_long = val;
         default:              ;
      endcase
   endtask

   task automatic drain;
      while (key_beat_q.size() != 0 || req_valid || char_due_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   // Most beats are tap runs on one key with random hold and gap times around the
   // configured window and long-press threshold; the rest are polls, noise and
   // broken press/release pairs.
   task automatic random_phase(input int n);
      int          stop;
      int          pick;
      int          k;
      int          k2;
      int          taps;
      logic [31:0] hold_ms;
      logic [31:0] gap_ms;
      stop = beat_cnt + n;
      while (beat_cnt < stop) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            k    = $urandom_range(19);
            taps = $urandom_range(1, 12);
            for (int i = 0; i < taps && beat_cnt < stop; i++) begin
               if ($urandom_range(7) == 0) hold_ms = cfg_long + $urandom_range(40);
               else if (cfg_long < 2) hold_ms = 0;
               else hold_ms = $urandom_range(cfg_long > 200 ? 199 : cfg_long - 1);
               if ($urandom_range(3) != 0)
                  gap_ms = (cfg_win < 2) ? 0 : $urandom_range(cfg_win > 250 ? 249 : cfg_win - 1);
               else
                  gap_ms = cfg_win + $urandom_range(100);
               key_tap(k, hold_ms, gap_ms);
               if ($urandom_range(5) == 0) send(1'b0, 8'($urandom_range(255)));
            end
         end else if (pick < 75) begin
            if ($urandom_range(9) == 0) ms_now = ms_now + $urandom;
            else ms_now = ms_now + $urandom_range(2 * cfg_win + 10);
            send(1'b0, 8'($urandom_range(255)));
         end else if (pick < 88) begin
            if ($urandom_range(1)) ms_now = $urandom;
            send(1'($urandom_range(1)), 8'($urandom_range(255)));
         end else begin
            k  = $urandom_range(19);
            k2 = $urandom_range(19);
            press(k, 1'($urandom_range(1)));
            ms_now += $urandom_range(100);
            if ($urandom_range(1)) lift(k2, 1'($urandom_range(1)));
            else press(k2, 1'($urandom_range(1)));
            ms_now += $urandom_range(100);
            lift(k, 1'($urandom_range(1)));
            lift(k2, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send(1'b0, 8'hFF);
      key_tap(0, 50, 50);
      key_tap(14, 30, 50);
      key_tap(14, 30, 50);
      ms_now += 400;
      send(1'b0, 8'h00);
      key_tap(5, 20, 40);
      key_tap(7, 20, 40);
      key_tap(8, 700, 40);
      press(13, 1'b0);
      lift(2, 1'b0);
      lift(13, 1'b0);
      press(0, 1'b0);
      press(13, 1'b0);
      lift(13, 1'b0);
      lift(0, 1'b0);
      send(1'b1, 8'h80);
      send(1'b1, 8'h7F);
      ms_now = 32'hFFFF_FFF0;
      key_tap(16, 700, 40);
      drain();

      set_reg(mtkd_pkg::REG_MODE, 16'd1);
      set_reg(mtkd_pkg::REG_WINDOW, 16'd300);
      set_reg(mtkd_pkg::REG_LONG, 16'd600);
      send_idle_pct = 27;
      recv_idle_pct = 67;
      hold_len      = 200;
      hold_seq++;
      random_phase(80);
      drain();

      set_reg(mtkd_pkg::REG_MODE, 16'd0);
      set_reg(mtkd_pkg::REG_WINDOW, 16'hFFFF);
      set_reg(mtkd_pkg::REG_LONG, 16'd0);
      send_idle_pct = 67;
      recv_idle_pct = 27;
      random_phase(70);
      drain();

      set_reg(mtkd_pkg::REG_MODE, 16'd1);
      set_reg(mtkd_pkg::REG_WINDOW, 16'd0);
      set_reg(mtkd_pkg::REG_LONG, 16'hFFFF);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(40);
      drain();

      set_reg(mtkd_pkg::REG_MODE, 16'($urandom_range(1)));
      set_reg(mtkd_pkg::REG_WINDOW, 16'($urandom_range(20, 1000)));
      set_reg(mtkd_pkg::REG_LONG, 16'($urandom_range(20, 1500)));
      random_phase(45);
      drain();

      if (fail_cnt == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
